// ===== rtl/core/rbs_pkg.sv =====
// Shared types, constants and helper functions for the blink sequencer.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps
`default_nettype none

package rbs_pkg;

   localparam int DUR_W  = 24;            // duration register width
   localparam int SPAN_W = DUR_W + 1;     // max - min + 1 can reach 2^DUR_W
   localparam int WORD_W = 32;            // time and generator word width

   localparam logic [1:0] PH_OPEN    = 2'd0;
   localparam logic [1:0] PH_CLOSING = 2'd1;
   localparam logic [1:0] PH_OPENING = 2'd2;

   localparam logic [2:0] CSR_PRNG_SEED      = 3'd0;
   localparam logic [2:0] CSR_FIRST_INTERVAL = 3'd1;
   localparam logic [2:0] CSR_CLOSE_MIN      = 3'd2;
   localparam logic [2:0] CSR_CLOSE_MAX      = 3'd3;
   localparam logic [2:0] CSR_OPEN_MIN       = 3'd4;
   localparam logic [2:0] CSR_OPEN_MAX       = 3'd5;
   localparam logic [2:0] CSR_GAP_MIN        = 3'd6;
   localparam logic [2:0] CSR_GAP_MAX        = 3'd7;

   localparam logic [WORD_W-1:0] RST_PRNG_SEED      = 32'd123456789;
   localparam logic [DUR_W-1:0]  RST_FIRST_INTERVAL = 24'd500000;
   localparam logic [DUR_W-1:0]  RST_CLOSE_MIN      = 24'd100000;
   localparam logic [DUR_W-1:0]  RST_CLOSE_MAX      = 24'd150000;
   localparam logic [DUR_W-1:0]  RST_OPEN_MIN       = 24'd120000;
   localparam logic [DUR_W-1:0]  RST_OPEN_MAX       = 24'd200000;
   localparam logic [DUR_W-1:0]  RST_GAP_MIN        = 24'd2000000;
   localparam logic [DUR_W-1:0]  RST_GAP_MAX        = 24'd4000000;

   localparam logic [7:0] LEVEL_FULL = 8'd254;

   typedef struct packed {
      logic [WORD_W-1:0] now_us;
      logic              restart;
   } req_word_type;

   typedef struct packed {
      logic [1:0] phase;
      logic [7:0] upper_level;
      logic [6:0] lower_level;
   } rsp_word_type;

   // controller -> datapath
   typedef struct packed {
      logic latch;         // capture the request word
      logic step;          // phase test, start of a draw
      logic draw_finish;   // store min + remainder
      logic level;         // threshold evaluation
      logic level_finish;  // threshold from quotient
      logic emit;          // load the response register
   } rbs_cmd_type;

   // datapath -> controller
   typedef struct packed {
      logic restart;
      logic need_draw;
      logic need_div;
      logic div_done;
   } rbs_status_type;

   function automatic logic [WORD_W-1:0] xorshift32(input logic [WORD_W-1:0] w);
      logic [WORD_W-1:0] a;
      logic [WORD_W-1:0] b;
      a = w ^ (w << 13);
      b = a ^ (a >> 17);
      return b ^ (b << 5);
   endfunction

   // up*30/100 = up*3/10; /10 as *205 >> 11, exact below 1024
   function automatic logic [6:0] lower_of(input logic [7:0] up);
      logic [17:0] p;
      p = 18'(up) * 18'd615;
      return p[17:11];
   endfunction

endpackage

`default_nettype wire

// ===== rtl/core/rbs_divider.sv =====
// Radix-2 restoring divider, one quotient bit per cycle.
// Depends on rbs_pkg for the word widths.
`timescale 1ns / 1ps
`default_nettype none

module rbs_divider
   import rbs_pkg::*;
(
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              start,
   input  wire logic [WORD_W-1:0] dividend,
   input  wire logic [SPAN_W-1:0] divisor,
   output logic                   done,
   output logic [WORD_W-1:0]      quotient,
   output logic [SPAN_W-1:0]      remainder
);

   localparam int CNT_W = $clog2(WORD_W);

   logic                busy_ff;
   logic                done_ff;
   logic [CNT_W-1:0]    cnt_ff;
   logic [WORD_W-1:0]   quo_ff;
   logic [SPAN_W-1:0]   rem_ff;
   logic [SPAN_W-1:0]   div_ff;
   logic [SPAN_W:0]     trial;
   logic [SPAN_W:0]     diff;
   logic                fits;

   always_comb begin
      trial = {rem_ff, quo_ff[WORD_W-1]};
      diff  = trial - {1'b0, div_ff};
      fits  = trial >= {1'b0, div_ff};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else if (start) begin
         busy_ff <= 1'b1;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else if (busy_ff) begin
         cnt_ff  <= cnt_ff + 1'b1;
         busy_ff <= (cnt_ff != CNT_W'(WORD_W - 1));
         done_ff <= (cnt_ff == CNT_W'(WORD_W - 1));
      end else begin
         done_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         quo_ff <= dividend;
         rem_ff <= '0;
         div_ff <= divisor;
      end else if (busy_ff) begin
         quo_ff <= {quo_ff[WORD_W-2:0], fits};
         rem_ff <= fits ? diff[SPAN_W-1:0] : trial[SPAN_W-1:0];
      end
   end

   assign done      = done_ff;
   assign quotient  = quo_ff;
   assign remainder = rem_ff;

endmodule

`default_nettype wire

// ===== rtl/core/rbs_datapath.sv =====
// Datapath: configuration registers, sequencer state, draw and level math.
// Depends on rbs_pkg and rbs_divider.
`timescale 1ns / 1ps
`default_nettype none

module rbs_datapath
   import rbs_pkg::*;
(
   input  wire logic           clock,
   input  wire logic           reset,
   input  wire logic           csr_write,
   input  wire logic [2:0]     csr_index,
   input  wire logic [31:0]    csr_data,
   input  wire req_word_type   req_word,
   input  wire rbs_cmd_type    cmd,
   output rbs_status_type      status,
   output rsp_word_type        rsp_word
);

   // configuration
   logic [WORD_W-1:0] seed_ff;
   logic [DUR_W-1:0]  first_ff;
   logic [DUR_W-1:0]  close_min_ff, close_max_ff;
   logic [DUR_W-1:0]  open_min_ff, open_max_ff;
   logic [DUR_W-1:0]  gap_min_ff, gap_max_ff;

   // sequencer state
   logic [1:0]        phase_ff;
   logic [WORD_W-1:0] phase_start_ff;
   logic [DUR_W-1:0]  phase_length_ff;
   logic [WORD_W-1:0] last_end_ff;
   logic [DUR_W-1:0]  next_gap_ff;
   logic [WORD_W-1:0] prng_ff;

   // item working registers
   logic [WORD_W-1:0] now_ff;
   logic              restart_ff;
   logic [DUR_W-1:0]  lo_ff;
   logic [7:0]        up_ff;
   rsp_word_type      rsp_ff;

   // phase test
   logic [WORD_W-1:0] el_start, el_gap;
   logic              trig;
   logic [1:0]        phase_in;
   logic [DUR_W-1:0]  lo, hi;
   logic              has_range;
   logic [SPAN_W-1:0] span;
   logic [WORD_W-1:0] prng_in;

   // level
   logic [WORD_W-1:0] el_lvl;
   logic              lvl_done, active;
   logic [WORD_W-1:0] lvl_dividend;
   logic [7:0]        s_val;
   logic [7:0]        up_div;

   // divider
   logic              div_start, div_done;
   logic [WORD_W-1:0] div_dividend, div_quo;
   logic [SPAN_W-1:0] div_divisor, div_rem;
   logic [DUR_W-1:0]  drawn;

   always_comb begin
      el_start = now_ff - phase_start_ff;
      el_gap   = now_ff - last_end_ff;
      case (phase_ff)
         PH_CLOSING: begin
            trig     = el_start >= WORD_W'(phase_length_ff);
            lo       = open_min_ff;
            hi       = open_max_ff;
            phase_in = trig ? PH_OPENING : PH_CLOSING;
         end
         PH_OPENING: begin
            trig     = el_start >= WORD_W'(phase_length_ff);
            lo       = gap_min_ff;
            hi       = gap_max_ff;
            phase_in = trig ? PH_OPEN : PH_OPENING;
         end
         default: begin
            trig     = el_gap >= WORD_W'(next_gap_ff);
            lo       = close_min_ff;
            hi       = close_max_ff;
            phase_in = trig ? PH_CLOSING : PH_OPEN;
         end
      endcase
      has_range = hi > lo;
      span      = SPAN_W'(hi) - SPAN_W'(lo) + 1'b1;
      prng_in   = xorshift32(prng_ff);

      el_lvl       = now_ff - phase_start_ff;
      lvl_done     = el_lvl >= WORD_W'(phase_length_ff);
      active       = (phase_ff == PH_CLOSING) || (phase_ff == PH_OPENING);
      // elapsed < length < 2^24 here, so elapsed*255 fits the word
      lvl_dividend = {el_lvl[DUR_W-1:0], 8'd0} - WORD_W'(el_lvl[DUR_W-1:0]);

      // 254*s/255 for s in 0..254 is s-1 (s>0); opening mirrors it
      s_val = div_quo[7:0];
      if (phase_ff == PH_CLOSING) begin
         up_div = (s_val == 8'd0) ? 8'd0 : s_val - 8'd1;
      end else begin
         up_div = (s_val == 8'd0) ? LEVEL_FULL : LEVEL_FULL - s_val;
      end

      drawn = lo_ff + div_rem[DUR_W-1:0];

      status.restart   = restart_ff;
      status.need_draw = !restart_ff && trig && has_range;
      status.need_div  = active && !lvl_done;
      status.div_done  = div_done;

      div_start    = (cmd.step && status.need_draw) || (cmd.level && status.need_div);
      div_dividend = cmd.step ? prng_in : lvl_dividend;
      div_divisor  = cmd.step ? span : SPAN_W'(phase_length_ff);
   end

   rbs_divider u_divider (
      .clock     (clock),
      .reset     (reset),
      .start     (div_start),
      .dividend  (div_dividend),
      .divisor   (div_divisor),
      .done      (div_done),
      .quotient  (div_quo),
      .remainder (div_rem)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         seed_ff      <= RST_PRNG_SEED;
         first_ff     <= RST_FIRST_INTERVAL;
         close_min_ff <= RST_CLOSE_MIN;
         close_max_ff <= RST_CLOSE_MAX;
         open_min_ff  <= RST_OPEN_MIN;
         open_max_ff  <= RST_OPEN_MAX;
         gap_min_ff   <= RST_GAP_MIN;
         gap_max_ff   <= RST_GAP_MAX;
      end else if (csr_write) begin
         case (csr_index)
            CSR_PRNG_SEED:      seed_ff      <= csr_data;
            CSR_FIRST_INTERVAL: first_ff     <= csr_data[DUR_W-1:0];
            CSR_CLOSE_MIN:      close_min_ff <= csr_data[DUR_W-1:0];
            CSR_CLOSE_MAX:      close_max_ff <= csr_data[DUR_W-1:0];
            CSR_OPEN_MIN:       open_min_ff  <= csr_data[DUR_W-1:0];
            CSR_OPEN_MAX:       open_max_ff  <= csr_data[DUR_W-1:0];
            CSR_GAP_MIN:        gap_min_ff   <= csr_data[DUR_W-1:0];
            CSR_GAP_MAX:        gap_max_ff   <= csr_data[DUR_W-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff        <= PH_OPEN;
         phase_start_ff  <= '0;
         phase_length_ff <= '0;
         last_end_ff     <= '0;
         next_gap_ff     <= RST_FIRST_INTERVAL;
         prng_ff         <= RST_PRNG_SEED;
      end else if (cmd.step) begin
         if (restart_ff) begin
            phase_ff        <= PH_OPEN;
            phase_start_ff  <= '0;
            phase_length_ff <= '0;
            last_end_ff     <= '0;
            next_gap_ff     <= first_ff;
            prng_ff         <= seed_ff;
         end else begin
            phase_ff <= phase_in;
            if (trig) begin
               if (phase_in == PH_OPEN) begin
                  last_end_ff <= now_ff;
                  if (!has_range) next_gap_ff <= lo;
               end else begin
                  phase_start_ff <= now_ff;
                  if (!has_range) phase_length_ff <= lo;
               end
               if (has_range) prng_ff <= prng_in;
            end
         end
      end else if (cmd.draw_finish) begin
         if (phase_ff == PH_OPEN) begin
            next_gap_ff <= drawn;
         end else begin
            phase_length_ff <= drawn;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.latch) begin
         now_ff     <= req_word.now_us;
         restart_ff <= req_word.restart;
      end
      if (cmd.step) begin
         lo_ff <= lo;
         if (restart_ff) up_ff <= 8'd0;
      end
      if (cmd.level) begin
         if (!active) begin
            up_ff <= 8'd0;
         end else if (lvl_done) begin
            up_ff <= (phase_ff == PH_CLOSING) ? LEVEL_FULL : 8'd0;
         end
      end
      if (cmd.level_finish) up_ff <= up_div;
      if (cmd.emit) begin
         rsp_ff.phase       <= phase_ff;
         rsp_ff.upper_level <= up_ff;
         rsp_ff.lower_level <= lower_of(up_ff);
      end
   end

   assign rsp_word = rsp_ff;

endmodule

`default_nettype wire

// ===== rtl/core/rbs_ctrl.sv =====
// Sequencing state machine: each word goes through test, optional draw, level, emit; a restart skips to emit.
// Depends on rbs_pkg for the command and status structs.
`timescale 1ns / 1ps
`default_nettype none

module rbs_ctrl
   import rbs_pkg::*;
(
   input  wire logic           clock,
   input  wire logic           reset,
   input  wire logic           req_valid,
   output logic                req_stall,
   output logic                rsp_valid,
   input  wire logic           rsp_stall,
   input  wire rbs_status_type status,
   output rbs_cmd_type         cmd
);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_TEST,
      ST_DRAW,
      ST_LEVEL,
      ST_LDIV,
      ST_EMIT
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;

   always_comb begin
      state_in     = state_ff;
      cmd          = '0;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.latch = 1'b1;
               state_in  = ST_TEST;
            end
         end
         ST_TEST: begin
            cmd.step = 1'b1;
            if (status.restart) begin
               state_in = ST_EMIT;
            end else if (status.need_draw) begin
               state_in = ST_DRAW;
            end else begin
               state_in = ST_LEVEL;
            end
         end
         ST_DRAW: begin
            if (status.div_done) begin
               cmd.draw_finish = 1'b1;
               state_in        = ST_LEVEL;
            end
         end
         ST_LEVEL: begin
            cmd.level = 1'b1;
            state_in  = status.need_div ? ST_LDIV : ST_EMIT;
         end
         ST_LDIV: begin
            if (status.div_done) begin
               cmd.level_finish = 1'b1;
               state_in         = ST_EMIT;
            end
         end
         ST_EMIT: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               cmd.emit     = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_stall = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;

endmodule

`default_nettype wire

// ===== rtl/core/random_blink_sequencer_top.sv =====
// Top level of the random blink sequencer: controller plus datapath.
// Depends on rbs_pkg, rbs_ctrl, rbs_datapath (and rbs_divider below it).
`timescale 1ns / 1ps
`default_nettype none

// Three-phase eye-blink sequencer (open, closing, opening). Each request word
// carries a microsecond timestamp and a restart flag; each produces exactly one
// response word with the phase after the update and the upper/lower eyelid
// levels. Words are handled one at a time; a restart word skips the draw and
// level steps. A phase change that draws from a non-empty range adds a
// divide, and a level computed mid-ramp adds another; both run on one shared
// radix-2 divider that retires one quotient bit per cycle. A finished
// response sits in an output register, so the next request is taken even
// while the response is stalled. The CSR port is always ready; write it
// only while the block is idle. Register writes act on the next draw or
// restart.

module random_blink_sequencer_top
   import rbs_pkg::*;
(
   input  wire logic          clock,
   input  wire logic          reset,
   // request channel
   input  wire logic          req_valid,
   output logic               req_stall,
   input  wire req_word_type  req_word,
   // response channel
   output logic               rsp_valid,
   input  wire logic          rsp_stall,
   output rsp_word_type       rsp_word,
   // configuration writes
   input  wire logic          csr_valid,
   output logic               csr_ready,
   input  wire logic [2:0]    csr_index,
   input  wire logic [31:0]   csr_data
);

   rbs_cmd_type    cmd;
   rbs_status_type status;

   assign csr_ready = 1'b1;

   rbs_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .status    (status),
      .cmd       (cmd)
   );

   rbs_datapath u_datapath (
      .clock     (clock),
      .reset     (reset),
      .csr_write (csr_valid && csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .req_word  (req_word),
      .cmd       (cmd),
      .status    (status),
      .rsp_word  (rsp_word)
   );

   // one word in flight: an accepted word blocks the next one
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> req_stall)
      else $error("request accepted while a word is in flight");

   // eyes open means no lid coverage
   a_open_means_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_word.phase == PH_OPEN) |-> (rsp_word.upper_level == 8'd0))
      else $error("open phase reported with nonzero lid level");

   // level and phase stay in range
   a_level_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_word.upper_level <= LEVEL_FULL && rsp_word.phase <= PH_OPENING
                     && rsp_word.lower_level <= 7'd76))
      else $error("response field out of range");

   // the divider only finishes while a word is being worked on
   a_divider_idle_when_idle: assert property (@(posedge clock) disable iff (reset)
      (!req_stall) |-> !status.div_done)
      else $error("divider finished while no word was being processed");

endmodule

`default_nettype wire
